### hdl/two_key_sorted_insert_queue_assert.svh
// Assertion macros used by the queue's top-level RTL file.
`ifndef TWO_KEY_SORTED_INSERT_QUEUE_ASSERT_SVH
`define TWO_KEY_SORTED_INSERT_QUEUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TKSIQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TKSIQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/tksiq_pkg.sv
// Types and constants shared by the sorted insertion queue modules.
`timescale 1ns / 1ps
package tksiq_pkg;

    localparam int XY_W   = 10;
    localparam int KEY_W  = 16;
    localparam int FUNC_W = 2;
    localparam int HELD_W = 7;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [XY_W-1:0]   new_x;
        logic [XY_W-1:0]   new_y;
        logic [KEY_W-1:0]  new_major_key;
        logic [KEY_W-1:0]  new_minor_key;
    } t_in_beat;

    typedef struct packed {
        logic              out_valid;
        logic [XY_W-1:0]   out_x;
        logic [XY_W-1:0]   out_y;
        logic [KEY_W-1:0]  out_major_key;
        logic [KEY_W-1:0]  out_minor_key;
        logic              overflow;
        logic              table_empty;
        logic [HELD_W-1:0] entries_held;
    } t_out_beat;

    typedef struct packed {
        logic [XY_W-1:0]  x;
        logic [XY_W-1:0]  y;
        logic [KEY_W-1:0] major_key;
        logic [KEY_W-1:0] minor_key;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input beat, cursor to the head
        logic rd_en;     // read the table
        logic rd_prev;   // read one entry before the cursor
        logic wr_en;     // write the table at the cursor
        logic wr_new;    // write data is the new entry, else the last read
        logic k_inc;
        logic k_dec;
        logic k_to_cnt;  // cursor to the tail
        logic pos_save;  // remember the cursor as the insert position
        logic cnt_inc;
        logic pop_head;
        logic emit;      // load the output register
        logic emit_pop;
        logic emit_ovf;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic full;
        logic empty;
        logic k_at_end;
        logic k_at_pos;
        logic pass_lt;   // stored major key below the new one
        logic pass_eq;   // major key not above and minor key below
        logic out_free;
    } t_stat;

endpackage

### hdl/tksiq_ctrl.sv
// Controller state machine that sequences scan, shift, write and pop.
`timescale 1ns / 1ps
module tksiq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  tksiq_pkg::t_stat i_stat,
    output tksiq_pkg::t_cmd  o_cmd
);
    import tksiq_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CMP = 4'd3;
    localparam logic [3:0] S_SHIFT_RD = 4'd4;
    localparam logic [3:0] S_SHIFT_WR = 4'd5;
    localparam logic [3:0] S_WR_NEW   = 4'd6;
    localparam logic [3:0] S_POP      = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_phase, n_phase;
    logic       r_ovf, n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_ovf   <= n_ovf;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_ovf      = r_ovf;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_phase = 1'b0;
                n_ovf   = 1'b0;
                case (i_stat.func)
                    FUNC_INSERT: begin
                        if (i_stat.full) begin
                            n_ovf   = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_SCAN_RD;
                        end
                    end
                    FUNC_APPEND: begin
                        if (i_stat.full) begin
                            n_ovf   = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.k_to_cnt = 1'b1;
                            n_state        = S_WR_NEW;
                        end
                    end
                    FUNC_POP: begin
                        if (i_stat.empty) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            n_state     = S_POP;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN_RD: begin
                if (i_stat.k_at_end) begin
                    o_cmd.pos_save = 1'b1;
                    o_cmd.k_to_cnt = 1'b1;
                    n_state        = S_SHIFT_RD;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (!r_phase && i_stat.pass_lt) begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_SCAN_RD;
                end else if (i_stat.pass_eq) begin
                    o_cmd.k_inc = 1'b1;
                    n_phase     = 1'b1;
                    n_state     = S_SCAN_RD;
                end else begin
                    o_cmd.pos_save = 1'b1;
                    o_cmd.k_to_cnt = 1'b1;
                    n_state        = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_stat.k_at_pos) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_new  = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.k_dec = 1'b1;
                n_state     = S_SHIFT_RD;
            end
            S_WR_NEW: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_new  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                n_state       = S_DONE;
            end
            S_POP: begin
                if (i_stat.out_free) begin
                    o_cmd.pop_head = 1'b1;
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_pop = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_ovf = r_ovf;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/tksiq_dp.sv
// Datapath: circular entry memory, cursor, counters, compares and output register.
`timescale 1ns / 1ps
module tksiq_dp #(
    parameter int DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tksiq_pkg::t_in_beat  i_in_beat,
    input  tksiq_pkg::t_cmd      i_cmd,
    output tksiq_pkg::t_stat     o_stat,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output tksiq_pkg::t_out_beat o_out_beat
);
    import tksiq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    t_entry          r_mem [DEPTH];
    t_entry          r_rdata;
    t_in_beat        r_in;
    logic [CW-1:0]   r_k, n_k;
    logic [CW-1:0]   r_pos;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_head, n_head;
    logic            r_out_valid;
    t_out_beat       r_out;

    logic [CW-1:0]   s_rd_lidx;
    logic [AW-1:0]   s_rd_addr;
    logic [AW-1:0]   s_wr_addr;
    t_entry          s_wr_data;
    t_entry          s_new_entry;

    // Logical position from the head to a physical memory address.
    function automatic logic [AW-1:0] f_phys(input logic [CW-1:0] lidx,
                                             input logic [AW-1:0] head);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(lidx);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return AW'(sum);
    endfunction

    assign s_new_entry = '{x: r_in.new_x, y: r_in.new_y,
                           major_key: r_in.new_major_key,
                           minor_key: r_in.new_minor_key};
    assign s_rd_lidx = i_cmd.rd_prev ? (r_k - CW'(1)) : r_k;
    assign s_rd_addr = f_phys(s_rd_lidx, r_head);
    assign s_wr_addr = f_phys(r_k, r_head);
    assign s_wr_data = i_cmd.wr_new ? s_new_entry : r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[s_wr_addr] <= s_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[s_rd_addr];
        end
    end

    always_comb begin
        n_k = r_k;
        if (i_cmd.load) begin
            n_k = '0;
        end else if (i_cmd.k_to_cnt) begin
            n_k = r_count;
        end else if (i_cmd.k_inc) begin
            n_k = r_k + CW'(1);
        end else if (i_cmd.k_dec) begin
            n_k = r_k - CW'(1);
        end

        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop_head) begin
            n_count = r_count - CW'(1);
        end

        n_head = r_head;
        if (i_cmd.pop_head) begin
            n_head = (r_head == AW'(DEPTH - 1)) ? '0 : (r_head + AW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_pos       <= '0;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_k     <= n_k;
            r_count <= n_count;
            r_head  <= n_head;
            if (i_cmd.pos_save) begin
                r_pos <= r_k;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_beat;
        end
        if (i_cmd.emit) begin
            r_out.out_valid     <= i_cmd.emit_pop;
            r_out.out_x         <= i_cmd.emit_pop ? r_rdata.x : '0;
            r_out.out_y         <= i_cmd.emit_pop ? r_rdata.y : '0;
            r_out.out_major_key <= i_cmd.emit_pop ? r_rdata.major_key : '0;
            r_out.out_minor_key <= i_cmd.emit_pop ? r_rdata.minor_key : '0;
            r_out.overflow      <= i_cmd.emit_ovf;
            r_out.table_empty   <= (n_count == '0);
            r_out.entries_held  <= HELD_W'(n_count);
        end
    end

    assign o_stat.func     = r_in.func;
    assign o_stat.full     = (r_count == CW'(DEPTH));
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.k_at_end = (r_k == r_count);
    assign o_stat.k_at_pos = (r_k == r_pos);
    assign o_stat.pass_lt  = (r_rdata.major_key < r_in.new_major_key);
    assign o_stat.pass_eq  = (r_rdata.major_key <= r_in.new_major_key) &&
                             (r_rdata.minor_key < r_in.new_minor_key);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

### hdl/two_key_sorted_insert_queue.sv
// Top level of the two-key sorted insertion queue.
//
//   Channel   Direction  Handshake                Beat type
//   input     in         i_in_valid / o_in_stall  tksiq_pkg::t_in_beat
//   output    out        o_out_valid / i_out_stall tksiq_pkg::t_out_beat
//
// A sorted insert scans from the head for its place, then shifts each entry behind it one place
// toward the tail and writes the new entry; an append writes at the tail and a pop reads the head.
// Each scan and shift step reads and then compares or writes: memory gives one read per cycle.
// Reset is synchronous and active low; it empties the table without touching memory.
// The next beat is taken in the cycle after the emit, even while that result waits in the
// output register; a stalled output holds its beat and delays the following emit.
`timescale 1ns / 1ps
`include "two_key_sorted_insert_queue_assert.svh"
module two_key_sorted_insert_queue #(
    parameter int DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tksiq_pkg::t_in_beat  i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tksiq_pkg::t_out_beat o_out_beat
);
    import tksiq_pkg::*;

    // The controller sees status flags and the input valid and drives commands and the input stall;
    // all entry storage, including the circular entry memory, lives in the datapath.
    t_cmd  s_cmd;
    t_stat s_stat;

    tksiq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd)
    );

    // The datapath keeps entries in a ring addressed from a head pointer, so a pop
    // only advances the head and never moves the remaining entries.
    tksiq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_beat   (i_in_beat),
        .i_cmd       (s_cmd),
        .o_stat      (s_stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

    // A result must never overwrite a beat that is still waiting downstream.
    `TKSIQ_ASSERT_SAME(a_emit_slot_free, s_cmd.emit, s_stat.out_free, "result emitted while output busy")
    // The table is never written while it holds DEPTH entries.
    `TKSIQ_ASSERT_SAME(a_no_write_full, s_cmd.wr_en, !s_stat.full, "entry written into a full table")
    // Once a beat is accepted the block is busy in the following cycle.
    `TKSIQ_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "input not stalled after accept")

endmodule
